// ===== rtl/wsa_pkg.sv =====
// Package for the weighted scatter average unit.
// Types, constants and codes shared by the controller, datapath and top level.
`default_nettype none
package wsa_pkg;

  localparam int NODES_DEF     = 65536;
  localparam int MAX_EQ_DEF    = 5;
  localparam int EQ_FIELDS     = 5;
  localparam int SUM_W         = 48;
  localparam int CNT_W         = 16;
  localparam int VAL_W         = 32;
  localparam int WGT_W         = 4;
  localparam int PROD_W        = VAL_W + WGT_W + 1;
  localparam int IN_TDATA_W    = 232;
  localparam int OUT_TDATA_W   = 224;
  localparam int PADDR_W       = 4;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ACC   = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    REG_EQS   = 2'd0,
    REG_LIMIT = 2'd1,
    REG_GHOST = 2'd2
  } reg_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_RD_RD,
    ST_RD_LATCH,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [2:0]  eqs;
    logic [20:0] limit;
    logic        ghost;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic mem_rd;
    logic acc_wr;
    logic clr_wr;
    logic row_latch;
    logic div_start;
    logic lane_store;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic skip;
    logic clr_last;
    logic div_done;
    logic lane_last;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/weighted_scatter_average_unit.sv =====
// Top level of the weighted scatter average unit: APB registers and glue.
// Uses wsa_pkg, wsa_ctrl, wsa_datapath.
//
//  channel   direction  handshake              payload
//  s_axis    in         tvalid/tready          tdata items, tuser command
//  m_axis    out        tvalid/tready          tdata averages, tuser empty flag
//  apb       in         psel/penable/pready    3 registers at 0x0, 0x4, 0x8
//
// Accumulate: each transfer is accepted, its row read, then the update written; a skipped one stops after the row read.
// Read: row read and latch, one division per lane, lanes = min(MAX_EQUATIONS,5) + 1, on
// the single bit-serial divider shared by all lanes, then the output load.
// Clear and reset: a sweep over all NODES entries of the node memory, tready low.
// A waiting result sits in the output register; the next item is taken meanwhile.
`default_nettype none
module weighted_scatter_average_unit
  import wsa_pkg::*;
#(
  parameter int NODES         = NODES_DEF,
  parameter int MAX_EQUATIONS = MAX_EQ_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // node_index, cell_index, weight, value_eq0..value_eq4, temperature
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // command
  input  wire logic [1:0]             s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // read_node, avg_eq0..avg_eq4, avg_temperature, node_count
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  // empty_node
  output logic [0:0]                  m_axis_tuser,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [PADDR_W-1:0]     paddr,
  input  wire logic [31:0]            pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  cfg_t       cfg_q;
  dp_cmd_t    cmd;
  dp_status_t status;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.eqs   <= 3'd5;
      cfg_q.limit <= 21'h10_0000;
      cfg_q.ghost <= 1'b1;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_EQS:   cfg_q.eqs   <= pwdata[2:0];
        REG_LIMIT: cfg_q.limit <= pwdata[20:0];
        REG_GHOST: cfg_q.ghost <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_EQS:   prdata = 32'(cfg_q.eqs);
      REG_LIMIT: prdata = 32'(cfg_q.limit);
      REG_GHOST: prdata = 32'(cfg_q.ghost);
      default:   prdata = '0;
    endcase
  end

  wsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_cmd_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  wsa_datapath #(
    .NODES         (NODES),
    .MAX_EQUATIONS (MAX_EQUATIONS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (s_axis_tdata),
    .out_data_o  (m_axis_tdata),
    .out_empty_o (m_axis_tuser[0]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready)
  );

endmodule
`default_nettype wire

// ===== rtl/wsa_div.sv =====
// Bit-serial unsigned divider, one quotient bit a cycle.
// Uses wsa_pkg widths.
`default_nettype none
module wsa_div
  import wsa_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [SUM_W-1:0] dividend_i,
  input  wire logic [CNT_W-1:0] divisor_i,
  output logic                  busy_o,
  output logic                  done_o,
  output logic [SUM_W-1:0]      quotient_o
);

  logic [SUM_W-1:0] quo_q;
  logic [CNT_W-1:0] rem_q, div_q;
  logic [5:0]       cnt_q;
  logic             busy_q, done_q;
  logic [CNT_W:0]   rem_sh;
  logic [CNT_W+1:0] diff;

  assign rem_sh = {rem_q, quo_q[SUM_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'(SUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[SUM_W-2:0], ~diff[CNT_W+1]};
      rem_q <= diff[CNT_W+1] ? rem_sh[CNT_W-1:0] : diff[CNT_W-1:0];
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

// ===== rtl/wsa_datapath.sv =====
// Datapath: node memory, weighted accumulate, read-out lanes and output register.
// Uses wsa_pkg and wsa_div; driven by wsa_ctrl.
`default_nettype none
module wsa_datapath
  import wsa_pkg::*;
#(
  parameter int NODES         = NODES_DEF,
  parameter int MAX_EQUATIONS = MAX_EQ_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire cfg_t                   cfg_i,
  input  wire dp_cmd_t                cmd_i,
  output dp_status_t                  status_o,
  input  wire logic [IN_TDATA_W-1:0]  in_data_i,
  output logic [OUT_TDATA_W-1:0]      out_data_o,
  output logic                        out_empty_o,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i
);

  localparam int NEQ = (MAX_EQUATIONS < EQ_FIELDS) ? MAX_EQUATIONS : EQ_FIELDS;
  localparam int NL  = NEQ + 1;
  localparam int AW  = $clog2(NODES);
  localparam int LW  = $clog2(NL);
  localparam int RW  = 1 + CNT_W + SUM_W * NL;
  localparam int LANE0 = 1 + CNT_W;

  logic [15:0]               node_q;
  logic [19:0]               cell_q;
  logic [WGT_W-1:0]          w_q;
  logic signed [VAL_W-1:0]   val_q  [NL];
  logic signed [PROD_W-1:0]  prod_q [NL];
  logic [RW-1:0]             mem [NODES];
  logic [RW-1:0]             rdata_q, new_row, wdata;
  logic [AW-1:0]             addr, waddr, clr_cnt_q;
  logic [31:0]               node_ext;
  logic                      in_range, we;
  logic [2:0]                n_act;
  logic [SUM_W-1:0]          sums_q [NL];
  logic [CNT_W-1:0]          cnt_q;
  logic [LW-1:0]             lane_q;
  logic [VAL_W-1:0]          avg_q [NL];
  logic [SUM_W-1:0]          dividend, quotient;
  logic                      div_busy, div_done;
  logic [VAL_W-1:0]          avg_sat;
  logic [SUM_W-1:0]          cur_sum;
  logic [VAL_W-1:0]          eq_out [EQ_FIELDS];
  logic [OUT_TDATA_W-1:0]    out_q;
  logic                      empty_q, out_valid_q;

  assign node_ext = 32'(node_q);
  assign addr     = node_ext[AW-1:0];
  assign in_range = node_ext < 32'(NODES);
  assign n_act    = (cfg_i.eqs > 3'(NEQ)) ? 3'(NEQ) : cfg_i.eqs;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      node_q <= in_data_i[15:0];
      cell_q <= in_data_i[35:16];
      w_q    <= in_data_i[39:36];
      for (int k = 0; k < NEQ; k++) val_q[k] <= in_data_i[40+VAL_W*k +: VAL_W];
      val_q[NEQ] <= in_data_i[200 +: VAL_W];
    end
    if (cmd_i.mem_rd) begin
      for (int k = 0; k < NL; k++) prod_q[k] <= val_q[k] * $signed({1'b0, w_q});
    end
  end

  always_comb begin
    logic                   ov;
    logic [SUM_W-1:0]       old;
    logic signed [SUM_W:0]  s;
    logic [CNT_W:0]         c;
    ov = rdata_q[0];
    new_row = '0;
    new_row[0] = 1'b1;
    c = (ov ? {1'b0, rdata_q[CNT_W:1]} : '0) + (CNT_W+1)'(w_q);
    new_row[CNT_W:1] = c[CNT_W] ? {CNT_W{1'b1}} : c[CNT_W-1:0];
    for (int k = 0; k < NL; k++) begin
      old = ov ? rdata_q[LANE0+SUM_W*k +: SUM_W] : '0;
      s = $signed({old[SUM_W-1], old}) + (SUM_W+1)'(prod_q[k]);
      if (k == NEQ || k < int'(n_act)) begin
        if (s[SUM_W] != s[SUM_W-1])
          new_row[LANE0+SUM_W*k +: SUM_W] = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                                     : {1'b0, {(SUM_W-1){1'b1}}};
        else
          new_row[LANE0+SUM_W*k +: SUM_W] = s[SUM_W-1:0];
      end else begin
        new_row[LANE0+SUM_W*k +: SUM_W] = old;
      end
    end
  end

  assign we    = cmd_i.clr_wr | cmd_i.acc_wr;
  assign waddr = cmd_i.clr_wr ? clr_cnt_q : addr;
  assign wdata = cmd_i.clr_wr ? '0 : new_row;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (cmd_i.mem_rd) rdata_q <= mem[addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_cnt_q <= (clr_cnt_q == AW'(NODES - 1)) ? '0 : clr_cnt_q + AW'(1);
    end
  end

  assign cur_sum  = sums_q[lane_q];
  assign dividend = cur_sum[SUM_W-1] ? -cur_sum : cur_sum;

  wsa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (cnt_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    if (cur_sum[SUM_W-1]) begin
      if (quotient > SUM_W'(64'h8000_0000)) avg_sat = 32'h8000_0000;
      else avg_sat = -quotient[VAL_W-1:0];
    end else begin
      if (quotient > SUM_W'(64'h7FFF_FFFF)) avg_sat = 32'h7FFF_FFFF;
      else avg_sat = quotient[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.row_latch) begin
      cnt_q <= (in_range && rdata_q[0]) ? rdata_q[CNT_W:1] : '0;
      for (int k = 0; k < NL; k++) sums_q[k] <= rdata_q[LANE0+SUM_W*k +: SUM_W];
    end
    if (cmd_i.lane_store) avg_q[lane_q] <= avg_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_q <= '0;
    end else if (cmd_i.row_latch) begin
      lane_q <= '0;
    end else if (cmd_i.lane_store && lane_q != LW'(NL - 1)) begin
      lane_q <= lane_q + LW'(1);
    end
  end

  always_comb begin
    for (int j = 0; j < EQ_FIELDS; j++) eq_out[j] = '0;
    for (int j = 0; j < NEQ; j++)
      if (cnt_q != '0 && j < int'(n_act)) eq_out[j] = avg_q[j];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q   <= {cnt_q, (cnt_q != '0) ? avg_q[NEQ] : {VAL_W{1'b0}},
                  eq_out[4], eq_out[3], eq_out[2], eq_out[1], eq_out[0], node_q};
      empty_q <= (cnt_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.out_load) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  assign status_o.skip      = !in_range || (cfg_i.ghost && {1'b0, cell_q} >= cfg_i.limit);
  assign status_o.clr_last  = (clr_cnt_q == AW'(NODES - 1));
  assign status_o.div_done  = div_done;
  assign status_o.lane_last = (lane_q == LW'(NL - 1));
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_data_o  = out_q;
  assign out_empty_o = empty_q;
  assign out_valid_o = out_valid_q;

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> !div_busy) else $error("divider restarted while busy");
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i)) else $error("result overwritten");
  a_wr_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.acc_wr |-> !cmd_i.clr_wr) else $error("sweep and update collide");
  a_sweep_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.clr_wr && clr_cnt_q == AW'(NODES - 1)) |=> clr_cnt_q == '0)
    else $error("sweep counter did not wrap");

endmodule
`default_nettype wire

// ===== rtl/wsa_ctrl.sv =====
// Controller state machine: sequences clear sweeps, accumulates and reads.
// Uses wsa_pkg; commands wsa_datapath.
`default_nettype none
module wsa_ctrl
  import wsa_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [1:0] in_cmd_i,
  output logic            in_ready_o,
  input  wire dp_status_t status_i,
  output dp_cmd_t         cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_CLEAR;
    else state_q <= state_d;
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          case (in_cmd_i)
            CMD_CLEAR: state_d = ST_CLEAR;
            CMD_ACC:   state_d = ST_ACC_RD;
            CMD_READ:  state_d = ST_RD_RD;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_ACC_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d = status_i.skip ? ST_IDLE : ST_ACC_WR;
      end
      ST_ACC_WR: begin
        cmd_o.acc_wr = 1'b1;
        state_d = ST_IDLE;
      end
      ST_RD_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d = ST_RD_LATCH;
      end
      ST_RD_LATCH: begin
        cmd_o.row_latch = 1'b1;
        state_d = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.lane_store = 1'b1;
          state_d = status_i.lane_last ? ST_OUT : ST_DIV_GO;
        end
      end
      ST_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== verif/wsa_average_checker.sv =====
// Checker for the weighted scatter average unit: watches the APB port and both streams,
// keeps its own node sums and counts, and compares every read transfer field by field.
// Depends on wsa_pkg.
`default_nettype none
module wsa_average_checker
  import wsa_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_tvalid_i,
  input  wire logic                   s_tready_i,
  input  wire logic [IN_TDATA_W-1:0]  s_tdata_i,
  input  wire logic [1:0]             s_tuser_i,
  input  wire logic                   m_tvalid_i,
  input  wire logic                   m_tready_i,
  input  wire logic [OUT_TDATA_W-1:0] m_tdata_i,
  input  wire logic [0:0]             m_tuser_i,
  input  wire logic                   psel_i,
  input  wire logic                   penable_i,
  input  wire logic                   pwrite_i,
  input  wire logic                   pready_i,
  input  wire logic [PADDR_W-1:0]     paddr_i,
  input  wire logic [31:0]            pwdata_i,
  output int                          errors_o,
  output int                          waiting_o,
  output int                          items_o,
  output int                          reads_o
);

  localparam longint SumMax = 64'sh7FFF_FFFF_FFFF;
  localparam longint SumMin = -SumMax - 1;

  typedef struct packed {
    logic [15:0]      node;
    logic [5:0][31:0] avg;   // equations 0..4, then temperature
    logic [15:0]      count;
    logic             empty;
  } average_t;

  longint      eq_sum [NODES_DEF][EQ_FIELDS];
  longint      temp_sum [NODES_DEF];
  int unsigned weight_cnt [NODES_DEF];
  bit [NODES_DEF-1:0] node_live;
  logic [2:0]  eqs_cfg;
  logic [20:0] limit_cfg;
  logic        ghost_cfg;
  average_t    expected_averages [$];

  function automatic longint sat48(longint s);
    if (s > SumMax) return SumMax;
    if (s < SumMin) return SumMin;
    return s;
  endfunction

  function automatic logic [31:0] node_average(longint sum, int unsigned cnt);
    longint q;
    q = sum / longint'(cnt);
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[31:0];
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      if (errors_o < 10)
        $display("mismatch %s: expected %h, got %h", name, want, got);
      errors_o++;
    end
  endtask

  task automatic take_item(logic [1:0] cmd, logic [IN_TDATA_W-1:0] d);
    logic [15:0]        node;
    logic [19:0]        cell_idx;
    logic [3:0]         w;
    logic signed [31:0] v;
    int unsigned        n, cnt, c;
    average_t           r;
    node     = d[15:0];
    cell_idx = d[35:16];
    w        = d[39:36];
    n        = (eqs_cfg > 3'd5) ? 5 : eqs_cfg;
    case (cmd)
      CMD_CLEAR: node_live = '0;
      CMD_ACC: begin
        if (!(ghost_cfg && {1'b0, cell_idx} >= limit_cfg)) begin
          if (!node_live[node]) begin
            for (int j = 0; j < EQ_FIELDS; j++) eq_sum[node][j] = 0;
            temp_sum[node]   = 0;
            weight_cnt[node] = 0;
            node_live[node]  = 1'b1;
          end
          for (int j = 0; j < n; j++) begin
            v = d[40+32*j +: 32];
            eq_sum[node][j] = sat48(eq_sum[node][j] + longint'(v) * longint'(w));
          end
          v = d[200 +: 32];
          temp_sum[node] = sat48(temp_sum[node] + longint'(v) * longint'(w));
          c = weight_cnt[node] + w;
          weight_cnt[node] = (c > 65535) ? 65535 : c;
        end
      end
      CMD_READ: begin
        cnt = node_live[node] ? weight_cnt[node] : 0;
        r.node = node;
        for (int j = 0; j < EQ_FIELDS; j++)
          r.avg[j] = (cnt != 0 && j < n) ? node_average(eq_sum[node][j], cnt) : '0;
        r.avg[5] = (cnt != 0) ? node_average(temp_sum[node], cnt) : '0;
        r.count  = cnt[15:0];
        r.empty  = (cnt == 0);
        expected_averages.push_back(r);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    average_t e;
    if (!rst_ni) begin
      eqs_cfg   = 3'd5;
      limit_cfg = 21'd1048576;
      ghost_cfg = 1'b1;
      node_live = '0;
      expected_averages.delete();
      errors_o  = 0;
      waiting_o <= 0;
      items_o   <= 0;
      reads_o   <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (reg_e'(paddr_i[3:2]))
          REG_EQS:   eqs_cfg   = pwdata_i[2:0];
          REG_LIMIT: limit_cfg = pwdata_i[20:0];
          REG_GHOST: ghost_cfg = pwdata_i[0];
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) begin
        reads_o <= reads_o + 1;
        if (expected_averages.size() == 0) begin
          if (errors_o < 10) $display("unexpected result transfer %h", m_tdata_i);
          errors_o++;
        end else begin
          e = expected_averages.pop_front();
          check_field("read_node", e.node, m_tdata_i[15:0]);
          for (int j = 0; j < 6; j++)
            check_field($sformatf("avg%0d", j), e.avg[j], m_tdata_i[16+32*j +: 32]);
          check_field("node_count", e.count, m_tdata_i[223:208]);
          check_field("empty_node", e.empty, m_tuser_i[0]);
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        items_o <= items_o + 1;
        take_item(s_tuser_i, s_tdata_i);
      end
      waiting_o <= expected_averages.size();
    end
  end

endmodule
`default_nettype wire

// ===== verif/weighted_scatter_average_unit_test.sv =====
// Testbench top for the weighted scatter average unit: clock, reset, stimulus and verdict.
// Depends on wsa_pkg, weighted_scatter_average_unit and wsa_average_checker.
`default_nettype none
module weighted_scatter_average_unit_test;
  import wsa_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int         CYCLE_LIMIT = 6000000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]             s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [0:0]             m_axis_tuser;
  logic                   psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0]     paddr = '0;
  logic [31:0]            pwdata = '0;
  logic [31:0]            prdata;
  logic                   pready;
  int                     errors, waiting, items, reads;
  int                     cycles = 0;
  bit                     calm = 1'b0;
  logic [20:0]            limit_now = 21'd1048576;

  always #5 clk_i = ~clk_i;

  weighted_scatter_average_unit i_dut (.*);

  wsa_average_checker i_checker (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready),
    .s_tdata_i(s_axis_tdata), .s_tuser_i(s_axis_tuser),
    .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready),
    .m_tdata_i(m_axis_tdata), .m_tuser_i(m_axis_tuser),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .pready_i(pready),
    .paddr_i(paddr), .pwdata_i(pwdata),
    .errors_o(errors), .waiting_o(waiting), .items_o(items), .reads_o(reads)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("weighted_scatter_average_unit_test: FAIL");
      $finish;
    end
  end

  always @(negedge clk_i)
    m_axis_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 25);

  task automatic write_reg(reg_e r, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (r == REG_LIMIT) limit_now = value[20:0];
  endtask

  // block must be idle: no read outstanding, accumulates and clear sweep finished
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (waiting != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
  endtask

  task automatic configure(logic [2:0] eqs, logic [20:0] limit, logic ghost);
    settle();
    write_reg(REG_EQS, 32'(eqs));
    write_reg(REG_LIMIT, 32'(limit));
    write_reg(REG_GHOST, 32'(ghost));
  endtask

  task automatic push(logic [1:0] cmd, logic [15:0] node, logic [19:0] cell_idx,
                      logic [3:0] w, logic [5:0][31:0] vals);
    if (!calm && $urandom_range(0, 99) < 25) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {vals, w, cell_idx, node};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return '0;
      3: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [5:0][31:0] pick_values();
    logic [5:0][31:0] v;
    for (int j = 0; j < 6; j++) v[j] = pick_value();
    return v;
  endfunction

  function automatic logic [19:0] pick_cell();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 20'hFFFFF;
      2: return 20'(limit_now - 1);
      3: return 20'(limit_now);
      4: return 20'(limit_now + 1);
      default: return 20'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_node();
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 5));
    endcase
  endfunction

  task automatic random_items(int count, bit with_clear);
    int r;
    for (int i = 0; i < count; i++) begin
      if (with_clear && i == count / 2) begin
        push(CMD_CLEAR, pick_node(), pick_cell(), 4'($urandom), pick_values());
      end else begin
        r = $urandom_range(0, 99);
        if (r < 2)
          push(CMD_UNUSED, pick_node(), pick_cell(), 4'($urandom), pick_values());
        else if (r < 20)
          push(CMD_READ, pick_node(), pick_cell(), 4'($urandom), pick_values());
        else
          push(CMD_ACC, pick_node(), pick_cell(), 4'($urandom), pick_values());
      end
    end
  endtask

  initial begin
    logic [5:0][31:0] hi, lo;
    for (int j = 0; j < 6; j++) begin
      hi[j] = 32'h7FFF_FFFF;
      lo[j] = 32'h8000_0000;
    end
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    settle();

    // directed: empty reads, zero weight, extremes, unused command, clear
    push(CMD_READ, 16'd0, 20'd0, 4'd0, '0);
    push(CMD_READ, 16'hFFFF, 20'd0, 4'd0, '0);
    push(CMD_ACC, 16'd0, 20'd0, 4'd0, hi);
    push(CMD_READ, 16'd0, 20'd0, 4'd0, '0);
    push(CMD_ACC, 16'd0, 20'd0, 4'd15, hi);
    push(CMD_ACC, 16'd0, 20'hFFFFF, 4'd1, lo);
    push(CMD_READ, 16'd0, 20'd0, 4'd0, '0);
    push(CMD_ACC, 16'hFFFF, 20'hFFFFF, 4'd15, lo);
    push(CMD_ACC, 16'hFFFF, 20'd5, 4'd3, pick_values());
    push(CMD_READ, 16'hFFFF, 20'hFFFFF, 4'd15, '1);
    push(CMD_UNUSED, 16'd1, 20'd1, 4'd1, hi);
    push(CMD_READ, 16'd1, 20'd1, 4'd1, '0);
    push(CMD_CLEAR, 16'hFFFF, 20'hFFFFF, 4'd15, '1);
    push(CMD_READ, 16'd0, 20'd0, 4'd0, '0);
    push(CMD_ACC, 16'd0, 20'd7, 4'd1, 192'(64'h1_0000));
    push(CMD_READ, 16'd0, 20'd0, 4'd0, '0);

    configure(3'd1, 21'd0, 1'b1);
    push(CMD_ACC, 16'd2, 20'd0, 4'd9, hi);
    push(CMD_READ, 16'd2, 20'd0, 4'd0, '0);

    configure(3'd5, 21'd1048576, 1'b1);
    random_items(300, 1'b0);
    configure(3'd3, 21'd512, 1'b1);
    random_items(300, 1'b1);
    configure(3'd7, 21'h1FFFFF, 1'b0);
    calm = 1'b1;
    random_items(300, 1'b0);
    calm = 1'b0;
    configure(3'd0, 21'd1000, 1'b0);
    random_items(250, 1'b0);
    configure(3'd6, 21'd0, 1'b1);
    random_items(150, 1'b0);
    configure(3'd2, 21'd70000, 1'b1);
    random_items(300, 1'b1);
    configure(3'd4, 21'd1048575, 1'b0);
    random_items(300, 1'b0);

    // drive one node with extreme values of both signs at full weight
    configure(3'd5, 21'd1048576, 1'b0);
    calm = 1'b1;
    for (int i = 0; i < 30; i++)
      push(CMD_ACC, 16'd7, 20'($urandom), 4'd15,
           {hi[5], 32'($urandom), lo[3], 32'($urandom), lo[1], hi[0]});
    calm = 1'b0;
    push(CMD_READ, 16'd7, 20'd0, 4'd0, '0);
    push(CMD_ACC, 16'd7, 20'd0, 4'd15, lo);
    push(CMD_READ, 16'd7, 20'd0, 4'd0, '0);

    s_axis_tvalid <= 1'b0;
    while (waiting != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    $display("covered %0d input transfers and %0d result transfers over nine register",
             items, reads);
    $display("settings, with clears, ghost filtering, unused commands and extreme values");
    if (errors == 0 && waiting == 0) begin
      $display("weighted_scatter_average_unit_test: PASS");
    end else begin
      $display("weighted_scatter_average_unit_test: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/wsa_pkg.sv
rtl/wsa_div.sv
rtl/wsa_datapath.sv
rtl/wsa_ctrl.sv
rtl/weighted_scatter_average_unit.sv
verif/wsa_average_checker.sv
verif/weighted_scatter_average_unit_test.sv
